// ===== src/prn_pkg.sv =====
`timescale 1ns / 1ps

package prn_pkg;

    // Coordinate format: only the low COORD_W bits of each coordinate port are used
    localparam int COORD_PORT_W = 32;
    localparam int COORD_W      = 32;
    localparam int MAG_W        = 32;              // magnitude of a coordinate, up to 2^31

    // Square root chain: one cell per root bit
    localparam int ROOT_W       = 32;
    localparam int SQ_W         = 2 * ROOT_W;      // squares and their sum
    localparam int REM_W        = ROOT_W + 2;      // partial remainder of the root
    localparam int SQRT_CELLS   = ROOT_W;

    // Normalizing divide: one cell per quotient bit
    localparam int CUT_W        = 31;
    localparam int DREM_W       = CUT_W + 1;
    localparam int QUO_W        = 17;
    localparam int DIV_CELLS    = QUO_W;

    // Configuration registers
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = CUT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF     = 1'd1;
    localparam logic [CUT_W-1:0]     CUTOFF_RST     = 31'd655360;

    // Word handed along the square root chain
    typedef struct packed {
        logic              valid;
        logic [SQ_W-1:0]   rad;    // radicand bits still to be brought down, msb first
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt_word;

    // Word handed along the divide chain
    typedef struct packed {
        logic              valid;
        logic [DREM_W-1:0] rem;
        logic [QUO_W-1:0]  quo;
    } t_div_word;

endpackage

// ===== src/point_range_normalizer.sv =====
`timescale 1ns / 1ps

// Point range normalizer. Takes one point word per cycle (signed Q16.16 x, y, z
// plus a point-valid flag) and returns one 17-bit unsigned Q1.16 word: the
// distance clamped to [0, cutoff] and divided by the cutoff, 65536 = 1.0.
// Distance is z in depth mode, else floor(sqrt(x^2 + y^2 + z^2)). An invalid
// point or a zero cutoff gives 0. Throughput is one word per cycle while
// o_stall is low; the path runs through three front stages (magnitude,
// squares, sum), a 32-cell square root chain, one clamp stage and a 17-cell
// divide chain. A two-entry output buffer lets the pipeline keep taking words
// while a result waits; o_stall rises only when both entries are held. The
// user must write configuration only while idle; the block does not enforce it.
module point_range_normalizer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_wr_en,
    input  logic [prn_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [prn_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // point input
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_point_valid,
    input  logic signed [prn_pkg::COORD_PORT_W-1:0] i_x_coord,
    input  logic signed [prn_pkg::COORD_PORT_W-1:0] i_y_coord,
    input  logic signed [prn_pkg::COORD_PORT_W-1:0] i_z_coord,
    // result output
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [prn_pkg::QUO_W-1:0]          o_normalized_value
);
    import prn_pkg::*;

    localparam int EXT_W = COORD_PORT_W + 1 - COORD_W;

    logic               r_depth_mode;
    logic [CUT_W-1:0]   r_cutoff;

    logic               w_adv;
    logic [MAG_W:0]     w_xs, w_ys, w_zs;
    logic [MAG_W-1:0]   w_ax, w_ay, w_az;
    logic [MAG_W-1:0]   n_ax, n_ay, n_az;

    logic               r_s0_valid;
    logic [MAG_W-1:0]   r_ax, r_ay, r_az;
    logic               r_s1_valid;
    logic [SQ_W-1:0]    r_sqx, r_sqy, r_sqz;
    logic               r_s2_valid;
    logic [SQ_W-1:0]    r_sum;

    t_sqrt_word         w_sq [0:SQRT_CELLS];
    t_div_word          w_dv [0:DIV_CELLS];

    logic               r_cl_valid;
    logic [DREM_W-1:0]  r_cl_dist;
    logic [DREM_W-1:0]  w_root, w_cut, w_clamp;

    logic               w_tail_valid;
    logic [QUO_W-1:0]   w_tail_value;
    logic               w_out_take;
    logic               r_out_valid;
    logic [QUO_W-1:0]   r_out_value;
    logic               r_skd_valid;
    logic [QUO_W-1:0]   r_skd_value;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode <= 1'b0;
            r_cutoff     <= CUTOFF_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_DEPTH_MODE: r_depth_mode <= i_cfg_data[0];
                CFG_CUTOFF:     r_cutoff     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Whole pipeline moves unless the output buffer is full
    assign w_adv   = !r_skd_valid;
    assign o_stall = r_skd_valid;

    // Sign-extend from COORD_W and take magnitudes
    assign w_xs = {{EXT_W{i_x_coord[COORD_W-1]}}, i_x_coord[COORD_W-1:0]};
    assign w_ys = {{EXT_W{i_y_coord[COORD_W-1]}}, i_y_coord[COORD_W-1:0]};
    assign w_zs = {{EXT_W{i_z_coord[COORD_W-1]}}, i_z_coord[COORD_W-1:0]};
    assign w_ax = w_xs[MAG_W] ? MAG_W'(~w_xs + 1'b1) : w_xs[MAG_W-1:0];
    assign w_ay = w_ys[MAG_W] ? MAG_W'(~w_ys + 1'b1) : w_ys[MAG_W-1:0];
    assign w_az = w_zs[MAG_W] ? MAG_W'(~w_zs + 1'b1) : w_zs[MAG_W-1:0];

    // Depth mode runs z through the root as sqrt(z^2); negative z clamps to 0
    always_comb begin
        n_ax = '0;
        n_ay = '0;
        n_az = '0;
        if (i_point_valid) begin
            if (r_depth_mode) begin
                n_az = w_zs[MAG_W] ? '0 : w_zs[MAG_W-1:0];
            end else begin
                n_ax = w_ax;
                n_ay = w_ay;
                n_az = w_az;
            end
        end
    end

    // Front stages: magnitude, squares, sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ax  <= n_ax;
            r_ay  <= n_ay;
            r_az  <= n_az;
            r_sqx <= SQ_W'(r_ax) * SQ_W'(r_ax);
            r_sqy <= SQ_W'(r_ay) * SQ_W'(r_ay);
            r_sqz <= SQ_W'(r_az) * SQ_W'(r_az);
            r_sum <= r_sqx + r_sqy + r_sqz;
        end
    end

    // Square root chain
    always_comb begin
        w_sq[0]       = '0;
        w_sq[0].valid = r_s2_valid;
        w_sq[0].rad   = r_sum;
    end

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        prn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_word  (w_sq[g]),
            .o_word  (w_sq[g+1])
        );
    end

    // Clamp to the cutoff
    assign w_root  = DREM_W'(w_sq[SQRT_CELLS].root);
    assign w_cut   = {1'b0, r_cutoff};
    assign w_clamp = (w_root > w_cut) ? w_cut : w_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cl_valid <= 1'b0;
        end else if (w_adv) begin
            r_cl_valid <= w_sq[SQRT_CELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cl_dist <= w_clamp;
        end
    end

    // Divide chain
    always_comb begin
        w_dv[0]       = '0;
        w_dv[0].valid = r_cl_valid;
        w_dv[0].rem   = r_cl_dist;
    end

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        prn_div_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_adv),
            .i_cutoff (r_cutoff),
            .i_word   (w_dv[g]),
            .o_word   (w_dv[g+1])
        );
    end

    // Zero cutoff forces a zero result
    assign w_tail_valid = w_dv[DIV_CELLS].valid;
    assign w_tail_value = (r_cutoff == '0) ? '0 : w_dv[DIV_CELLS].quo;

    // Output register plus skid entry
    assign w_out_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (w_out_take) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end
        end else if (r_out_valid && !w_out_take) begin
            r_skd_valid <= w_tail_valid;
        end else begin
            r_out_valid <= w_tail_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (w_out_take) begin
                r_out_value <= r_skd_value;
            end
        end else if (r_out_valid && !w_out_take) begin
            r_skd_value <= w_tail_value;
        end else begin
            r_out_value <= w_tail_value;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_normalized_value = r_out_value;

endmodule

// ===== src/prn_sqrt_cell.sv =====
`timescale 1ns / 1ps

// One digit of a restoring square root: brings down two radicand bits and
// settles one root bit.
module prn_sqrt_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  prn_pkg::t_sqrt_word  i_word,
    output prn_pkg::t_sqrt_word  o_word
);
    import prn_pkg::*;

    logic [REM_W+1:0] w_rem_sh;
    logic [REM_W+1:0] w_trial;
    logic [REM_W+1:0] w_diff;
    logic             w_take;
    t_sqrt_word       n_word;
    logic             r_valid;
    t_sqrt_word       r_word;

    // Trial subtract of (4*root + 1)
    assign w_rem_sh = {i_word.rem, i_word.rad[SQ_W-1 -: 2]};
    assign w_trial  = {2'b00, i_word.root, 2'b01};
    assign w_diff   = w_rem_sh - w_trial;
    assign w_take   = (w_rem_sh >= w_trial);

    always_comb begin
        n_word       = i_word;
        n_word.rad   = {i_word.rad[SQ_W-3:0], 2'b00};
        n_word.root  = {i_word.root[ROOT_W-2:0], w_take};
        n_word.rem   = w_take ? w_diff[REM_W-1:0] : w_rem_sh[REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    always_comb begin
        o_word       = r_word;
        o_word.valid = r_valid;
    end

endmodule

// ===== src/prn_div_cell.sv =====
`timescale 1ns / 1ps

// One quotient bit of a restoring divide by the cutoff.
module prn_div_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [prn_pkg::CUT_W-1:0]    i_cutoff,
    input  prn_pkg::t_div_word           i_word,
    output prn_pkg::t_div_word           o_word
);
    import prn_pkg::*;

    logic [DREM_W-1:0] w_div;
    logic [DREM_W-1:0] w_diff;
    logic              w_take;
    t_div_word         n_word;
    logic              r_valid;
    t_div_word         r_word;

    assign w_div  = {1'b0, i_cutoff};
    assign w_take = (i_word.rem >= w_div);
    assign w_diff = w_take ? (i_word.rem - w_div) : i_word.rem;

    // Remainder stays below the cutoff, so doubling fits
    always_comb begin
        n_word     = i_word;
        n_word.quo = {i_word.quo[QUO_W-2:0], w_take};
        n_word.rem = {w_diff[DREM_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    always_comb begin
        o_word       = r_word;
        o_word.valid = r_valid;
    end

endmodule

// ===== verif/point_range_normalizer_tb.sv =====
`timescale 1ns / 1ps

module point_range_normalizer_tb;

    import prn_pkg::*;

    localparam int PIPE_LAT    = 54;     // input accept to o_valid, no stall
    localparam int RAND_ITEMS  = 1050;
    localparam int RAND_PHASES = 10;
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int QUIET_LIMIT = 5000;   // cycles with no handshake at all

    localparam logic [COORD_PORT_W-1:0] CORNERS [5] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001
    };

    typedef enum int {
        STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC, STALL_TOGGLE
    } stall_pat_e;

    // Expected normalized values, in order, plus a private copy of the registers
    class norm_ledger;
        bit                 depth_mode;
        logic [CUT_W-1:0]   cutoff;
        logic [QUO_W-1:0]   want_q[$];
        int unsigned        words_in;
        int unsigned        words_out;
        int unsigned        errors;

        function new();
            depth_mode = 1'b0;
            cutoff     = CUTOFF_RST;
            words_in   = 0;
            words_out  = 0;
            errors     = 0;
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("[%0t] %s", $time, msg);
            errors++;
        endtask

        // low COORD_W bits, sign-extended
        function longint coord_value(logic [COORD_PORT_W-1:0] raw);
            logic [63:0] w;
            w = 64'(raw) << (64 - COORD_W);
            return $signed(w) >>> (64 - COORD_W);
        endfunction

        function longint unsigned magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // floor(sqrt(n)), one root bit at a time from the top
        function longint unsigned floor_root(longint unsigned n);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = ROOT_W - 1; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= n)
                    root = trial;
            end
            return root;
        endfunction

        function logic [QUO_W-1:0] normalized_of(bit pv, logic [COORD_PORT_W-1:0] x,
                                                 logic [COORD_PORT_W-1:0] y,
                                                 logic [COORD_PORT_W-1:0] z);
            longint          zs;
            longint unsigned ax, ay, az, span, quo;
            if (!pv || cutoff == '0)
                return '0;
            if (depth_mode) begin
                zs   = coord_value(z);
                span = (zs < 0) ? 64'd0 : zs;
            end else begin
                ax   = magnitude(coord_value(x));
                ay   = magnitude(coord_value(y));
                az   = magnitude(coord_value(z));
                span = floor_root(ax * ax + ay * ay + az * az);
            end
            if (span > 64'(cutoff))
                span = 64'(cutoff);
            quo = (span << 16) / 64'(cutoff);
            return QUO_W'(quo);
        endfunction

        function void note_point(bit pv, logic [COORD_PORT_W-1:0] x,
                                 logic [COORD_PORT_W-1:0] y, logic [COORD_PORT_W-1:0] z);
            want_q.push_back(normalized_of(pv, x, y, z));
            words_in++;
        endfunction

        task check_value(logic [QUO_W-1:0] got);
            logic [QUO_W-1:0] want;
            if (want_q.size() == 0) begin
                report($sformatf("result word %0d with nothing expected", got));
            end else begin
                want = want_q.pop_front();
                if (got !== want)
                    report($sformatf("normalized_value mismatch on word %0d: got %0d, want %0d",
                                     words_out, got, want));
                words_out++;
            end
        endtask
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic                     i_point_valid;
    logic [COORD_PORT_W-1:0]  i_x_coord;
    logic [COORD_PORT_W-1:0]  i_y_coord;
    logic [COORD_PORT_W-1:0]  i_z_coord;
    logic                     o_valid;
    logic                     i_stall;
    logic [QUO_W-1:0]         o_normalized_value;

    norm_ledger  ledger;
    bit          hold_req = 1'b0;
    int unsigned held_cycles = 0;
    int unsigned settings = 0;
    int          quiet_cycles = 0;

    point_range_normalizer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_point_valid      (i_point_valid),
        .i_x_coord          (i_x_coord),
        .i_y_coord          (i_y_coord),
        .i_z_coord          (i_z_coord),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_normalized_value (o_normalized_value)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Offer one point word and hold it until taken
    task automatic send_point(bit pv, logic [COORD_PORT_W-1:0] x,
                              logic [COORD_PORT_W-1:0] y, logic [COORD_PORT_W-1:0] z);
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_point_valid <= pv;
        i_x_coord     <= x;
        i_y_coord     <= y;
        i_z_coord     <= z;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        ledger.note_point(pv, x, y, z);
    endtask

    // Drop valid and wait for every expected word to come out
    task automatic finish_phase();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (ledger.want_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Both registers, written back to back while the block is empty
    task automatic set_config(bit mode, logic [CUT_W-1:0] cut);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= CFG_DEPTH_MODE;
        i_cfg_data  <= CFG_DATA_W'(mode);
        @(negedge i_clk);
        i_cfg_idx   <= CFG_CUTOFF;
        i_cfg_data  <= cut;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        ledger.depth_mode = mode;
        ledger.cutoff     = cut;
        settings++;
    endtask

    // Mostly magnitudes around the cutoff, plus full-range, corners and tiny values
    function automatic logic [COORD_PORT_W-1:0] pick_coord(int unsigned cut);
        int unsigned mag;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return $urandom;
        if (r < 30)
            return CORNERS[$urandom_range(0, 4)];
        if (r < 40)
            return 32'($urandom_range(0, 511)) - 32'd256;
        mag = $urandom_range(0, cut) >> $urandom_range(0, 2);
        if ($urandom_range(0, 7) == 0)
            mag += $urandom_range(0, 16);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Random words in bursts with random gaps
    task automatic run_random(int n, int unsigned cut);
        int burst;
        int gap;
        burst = $urandom_range(1, 40);
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
                if (gap > 0) begin
                    @(negedge i_clk);
                    i_valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                    : $urandom_range(1, 40);
            end
            send_point($urandom_range(0, 9) != 0, pick_coord(cut), pick_coord(cut),
                       pick_coord(cut));
            burst--;
        end
    endtask

    // Receiver: stall patterns in segments, with one long hold on request
    initial begin : receiver
        stall_pat_e pat;
        int         seg_len;
        int         period;
        i_stall = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end else begin
                pat     = stall_pat_e'($urandom_range(0, 4));
                seg_len = $urandom_range(8, 64);
                period  = $urandom_range(2, 6);
                for (int k = 0; k < seg_len && !hold_req; k++) begin
                    @(negedge i_clk);
                    case (pat)
                        STALL_NONE:     i_stall <= 1'b0;
                        STALL_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
                        STALL_HEAVY:    i_stall <= ($urandom_range(0, 3) != 0);
                        STALL_PERIODIC: i_stall <= (k % period == 0);
                        default:        i_stall <= k[0];
                    endcase
                end
            end
        end
    end

    // Result check on every accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall)
            ledger.check_value(o_normalized_value);
        if (i_valid && o_stall === 1'b1)
            held_cycles++;
    end

    // Watchdog: too long without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        bit               mode;
        logic [CUT_W-1:0] cut;
        ledger        = new();
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_idx     = CFG_DEPTH_MODE;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_point_valid = 1'b0;
        i_x_coord     = '0;
        i_y_coord     = '0;
        i_z_coord     = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // range mode, reset cutoff of 10 m
        send_point(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);   // invalid point
        send_point(1'b1, 32'd0, 32'd0, 32'd0);
        send_point(1'b1, 32'd655360, 32'd0, 32'd0);                      // exactly at cutoff
        send_point(1'b1, 32'd327680, 32'd0, 32'd0);
        send_point(1'b1, -32'sd327680, 32'd0, 32'd0);
        send_point(1'b1, 32'd3 << 16, 32'd4 << 16, 32'd0);               // 3-4-5
        send_point(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);   // largest sum
        send_point(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(1'b1, 32'd1, 32'd0, 32'd0);                           // truncates to 0
        send_point(1'b1, 32'd10, 32'd0, 32'd0);
        send_point(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(1'b1, 32'd655359, 32'd0, 32'd0);                      // just below cutoff
        finish_phase();

        // depth mode
        set_config(1'b1, CUTOFF_RST);
        send_point(1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF);                   // negative depth
        send_point(1'b1, 32'd0, 32'd0, 32'h8000_0000);
        send_point(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd327680);
        send_point(1'b1, 32'd0, 32'd0, 32'd655360);
        send_point(1'b1, 32'd0, 32'd0, 32'h7FFF_FFFF);                   // beyond cutoff
        send_point(1'b0, 32'd0, 32'd0, 32'd327680);
        finish_phase();

        // zero cutoff
        set_config(1'b0, '0);
        send_point(1'b1, 32'd327680, 32'd0, 32'd0);
        send_point(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
        finish_phase();

        // widest cutoff, depth mode
        set_config(1'b1, '1);
        send_point(1'b1, 32'd0, 32'd0, 32'h7FFF_FFFF);
        send_point(1'b1, 32'd0, 32'd0, 32'h4000_0000);
        finish_phase();

        // smallest nonzero cutoff
        set_config(1'b0, CUT_W'(1));
        send_point(1'b1, 32'd1, 32'd0, 32'd0);
        send_point(1'b1, 32'd0, 32'd0, 32'd0);
        finish_phase();

        // random phases over a spread of register settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            mode = $urandom_range(0, 1);
            case (ph)
                0: begin mode = 1'b0; cut = CUTOFF_RST; end
                1: begin mode = 1'b1; cut = CUTOFF_RST; end
                2: begin mode = 1'b0; cut = '1; end
                3: begin mode = 1'b1; cut = '1; end
                4: begin mode = 1'b0; cut = CUT_W'(1); end
                5: begin mode = 1'b1; cut = CUT_W'(1); end
                6: cut = CUT_W'($urandom_range(1, 65535));
                7: cut = CUT_W'($urandom_range(65536, 32'h0100_0000));
                default: cut = CUT_W'($urandom);
            endcase
            set_config(mode, cut);
            if (ph == 2)
                hold_req = 1'b1;   // back up the pipeline once
            run_random(RAND_ITEMS / RAND_PHASES, cut);
            finish_phase();
        end

        // catch any stray output word
        repeat (2 * PIPE_LAT) @(posedge i_clk);
        if (ledger.want_q.size() != 0)
            ledger.report($sformatf("%0d expected words never came out", ledger.want_q.size()));

        $display("run covered %0d point words in, %0d result words checked, %0d settings",
                 ledger.words_in, ledger.words_out, settings);
        $display("input held off %0d cycles; %0d mismatches seen", held_cycles, ledger.errors);
        if (ledger.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
